// File: rtl/core/bspl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cubic B-spline curve sampler.
package bspl_pkg;

    // Datapath width; intermediates wrap as 64-bit two's complement
    localparam int ACC_W     = 64;
    // Curve parameter t: unsigned Q1.16, reaches 1.0 at the last sample
    localparam int T_W       = 17;
    localparam int FRAC_W    = 16;
    // Horner product is split into two halves of the accumulator
    localparam int HALF_W    = 32;
    // Divide by six: quotient digits of DIG_W bits, MSB first
    localparam int DIG_W     = 16;
    localparam int DIV_STEPS = 4;
    localparam int REM_W     = 3;
    // Shared loop counter in the sequencer
    localparam int CNT_W     = 2;
    // Running point number
    localparam int PNUM_W    = 16;

    // Defaults for the top-level parameters
    localparam int SAMPLES_PER_SEGMENT_DEF = 30;
    localparam int COORD_WIDTH_DEF         = 32;

    // Coefficient select codes (counter value while the Horner loop runs)
    localparam logic [CNT_W-1:0] SEL_C0 = 2'd0;
    localparam logic [CNT_W-1:0] SEL_C1 = 2'd1;
    localparam logic [CNT_W-1:0] SEL_C2 = 2'd2;
    localparam logic [CNT_W-1:0] SEL_C3 = 2'd3;

    // Datapath operations issued by the microcode
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_PREP1,
        UOP_PREP2,
        UOP_PREP3,
        UOP_LOAD,
        UOP_MUL_LO,
        UOP_MUL_HI,
        UOP_ADD,
        UOP_DIV_INIT,
        UOP_DIV,
        UOP_EMIT,
        UOP_NEXT,
        UOP_DONE
    } uop_t;

    // Control from the sequencer to the datapath
    typedef struct packed {
        uop_t             uop;
        logic [CNT_W-1:0] sel;
    } dp_ctrl_t;

    // Status from the datapath back to the sequencer
    typedef struct packed {
        logic start;
        logic out_busy;
        logic more_samples;
    } seq_status_t;

endpackage

// File: rtl/core/bspl_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control-word ROM and loop counter.
module bspl_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bspl_pkg::seq_status_t status,
    output bspl_pkg::dp_ctrl_t    dp_ctrl,
    output logic                  in_ready
);
    import bspl_pkg::*;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_CNT_NZ,
        COND_OUT_BUSY,
        COND_MORE
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        pc_t   target;
        logic  in_ready;
    } uword_t;

    // Program addresses
    localparam pc_t PC_WAIT     = pc_t'(0);
    localparam pc_t PC_PREP1    = pc_t'(1);
    localparam pc_t PC_PREP2    = pc_t'(2);
    localparam pc_t PC_PREP3    = pc_t'(3);
    localparam pc_t PC_LOAD     = pc_t'(4);
    localparam pc_t PC_MUL_LO   = pc_t'(5);
    localparam pc_t PC_MUL_HI   = pc_t'(6);
    localparam pc_t PC_ADD      = pc_t'(7);
    localparam pc_t PC_DIV_INIT = pc_t'(8);
    localparam pc_t PC_DIV      = pc_t'(9);
    localparam pc_t PC_EMIT     = pc_t'(10);
    localparam pc_t PC_NEXT     = pc_t'(11);
    localparam pc_t PC_DONE     = pc_t'(12);

    // Control store: one word per step
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        w = '{uop: UOP_NOP, cond: COND_ALWAYS, target: PC_WAIT, in_ready: 1'b0};
        case (pc)
            PC_WAIT:     w = '{UOP_NOP,      COND_NO_START, PC_WAIT,   1'b1};
            PC_PREP1:    w = '{UOP_PREP1,    COND_NEVER,    PC_WAIT,   1'b0};
            PC_PREP2:    w = '{UOP_PREP2,    COND_NEVER,    PC_WAIT,   1'b0};
            PC_PREP3:    w = '{UOP_PREP3,    COND_NEVER,    PC_WAIT,   1'b0};
            PC_LOAD:     w = '{UOP_LOAD,     COND_NEVER,    PC_WAIT,   1'b0};
            PC_MUL_LO:   w = '{UOP_MUL_LO,   COND_NEVER,    PC_WAIT,   1'b0};
            PC_MUL_HI:   w = '{UOP_MUL_HI,   COND_NEVER,    PC_WAIT,   1'b0};
            PC_ADD:      w = '{UOP_ADD,      COND_CNT_NZ,   PC_MUL_LO, 1'b0};
            PC_DIV_INIT: w = '{UOP_DIV_INIT, COND_NEVER,    PC_WAIT,   1'b0};
            PC_DIV:      w = '{UOP_DIV,      COND_CNT_NZ,   PC_DIV,    1'b0};
            PC_EMIT:     w = '{UOP_EMIT,     COND_OUT_BUSY, PC_EMIT,   1'b0};
            PC_NEXT:     w = '{UOP_NEXT,     COND_MORE,     PC_LOAD,   1'b0};
            PC_DONE:     w = '{UOP_DONE,     COND_ALWAYS,   PC_WAIT,   1'b0};
            default:     w = '{UOP_NOP,      COND_ALWAYS,   PC_WAIT,   1'b0};
        endcase
        return w;
    endfunction

    pc_t              pc_reg,  pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    uword_t           uword;
    logic             cond_true;

    // Fetch
    always_comb begin
        uword = ucode(pc_reg);
    end

    // Next step and loop counter
    always_comb begin
        case (uword.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_START: cond_true = !status.start;
            COND_CNT_NZ:   cond_true = (cnt_reg != '0);
            COND_OUT_BUSY: cond_true = status.out_busy;
            COND_MORE:     cond_true = status.more_samples;
            default:       cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uword.target : pc_reg + 1'b1;

        cnt_next = cnt_reg;
        case (uword.uop)
            UOP_LOAD:     cnt_next = SEL_C2;
            UOP_ADD:      cnt_next = cnt_reg - 1'b1;
            UOP_DIV_INIT: cnt_next = CNT_W'(DIV_STEPS - 1);
            UOP_DIV:      cnt_next = cnt_reg - 1'b1;
            default:      cnt_next = cnt_reg;
        endcase
    end

    // Outputs of the current word
    always_comb begin
        dp_ctrl  = '{uop: uword.uop, sel: cnt_reg};
        in_ready = uword.in_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_WAIT;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/bspl_lane.sv
`timescale 1ns / 1ps
// One coordinate lane: coefficients, Horner evaluation, divide by six, saturation.
module bspl_lane #(
    parameter int COORD_WIDTH = bspl_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  bspl_pkg::dp_ctrl_t            dp_ctrl,
    input  logic signed [COORD_WIDTH-1:0] p0,
    input  logic signed [COORD_WIDTH-1:0] p1,
    input  logic signed [COORD_WIDTH-1:0] p2,
    input  logic signed [COORD_WIDTH-1:0] p3,
    input  logic [bspl_pkg::T_W-1:0]      t,
    output logic signed [COORD_WIDTH-1:0] sample
);
    import bspl_pkg::*;

    localparam int LOP_W    = HALF_W + T_W;       // low half times t
    localparam int PLO_W    = LOP_W + 1;          // plus rounding constant
    localparam int HIP_W    = HALF_W + T_W + 1;   // signed high half times t
    localparam int PHI_W    = ACC_W - FRAC_W;     // bits of the high product kept
    localparam int W_W      = REM_W + DIG_W;      // partial dividend
    localparam int DIVP_W   = 2 * W_W;
    localparam int DIVISOR  = 6;
    localparam int HALF_DIV = 3;
    // Reciprocal of six, exact floor for partial dividends below 6 * 2^DIG_W
    localparam int DIV_SHIFT = DIG_W + 5;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / DIVISOR + 1;
    localparam logic [PLO_W-1:0] ROUND_HALF = PLO_W'(1 << (FRAC_W - 1));
    localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [ACC_W-1:0] p0_ext, p1_ext, p2_ext, p3_ext;
    logic [ACC_W-1:0]        c0_reg, c1_reg, c2_reg, c3_reg;
    logic [ACC_W-1:0]        h_reg, base_reg, qv_reg, coef_sel;
    logic [PLO_W-1:0]        plo_reg;
    logic [PHI_W-1:0]        phi_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [LOP_W-1:0]        lo_prod;
    logic signed [HALF_W-1:0] h_hi;
    logic signed [T_W:0]     t_s;
    logic signed [HIP_W-1:0] hi_prod;
    logic [ACC_W-1:0]        v_init;
    logic [W_W-1:0]          w, rem_full;
    logic [DIVP_W-1:0]       div_prod;
    logic [DIG_W-1:0]        qd;
    logic [ACC_W-COORD_WIDTH:0] upper;
    logic                    in_range;

    assign p0_ext = ACC_W'(p0);
    assign p1_ext = ACC_W'(p1);
    assign p2_ext = ACC_W'(p2);
    assign p3_ext = ACC_W'(p3);

    // Coefficient for the current Horner term
    always_comb begin
        case (dp_ctrl.sel)
            SEL_C0:  coef_sel = c0_reg;
            SEL_C1:  coef_sel = c1_reg;
            SEL_C2:  coef_sel = c2_reg;
            SEL_C3:  coef_sel = c3_reg;
            default: coef_sel = c0_reg;
        endcase
    end

    // Split multiply: unsigned low half, signed high half
    assign lo_prod = LOP_W'(h_reg[HALF_W-1:0]) * LOP_W'(t);
    assign h_hi    = h_reg[ACC_W-1:HALF_W];
    assign t_s     = {1'b0, t};
    assign hi_prod = HIP_W'(h_hi) * HIP_W'(t_s);

    // h / 6 rounded half up starts from floor((h + 3) / 6)
    assign v_init = h_reg + ACC_W'(HALF_DIV);

    // One quotient digit of the divide by six
    assign w        = {rem_reg, qv_reg[ACC_W-1 -: DIG_W]};
    assign div_prod = DIVP_W'(w) * DIVP_W'(DIV_RECIP);
    assign qd       = div_prod[DIV_SHIFT +: DIG_W];
    assign rem_full = w - W_W'(qd) * W_W'(DIVISOR);

    // Datapath registers, one operation per step
    always_ff @(posedge aclk) begin
        case (dp_ctrl.uop)
            UOP_PREP1: begin
                c3_reg <= p3_ext - p0_ext;
                c2_reg <= p1_ext - p2_ext;
                c1_reg <= p2_ext - p0_ext;
                c0_reg <= p0_ext + p2_ext;
            end
            UOP_PREP2: begin
                c3_reg <= c3_reg + (c2_reg << 1) + c2_reg;
                c2_reg <= c0_reg - (p1_ext << 1);
                c1_reg <= c1_reg + (c1_reg << 1);
                c0_reg <= c0_reg + (p1_ext << 2);
            end
            UOP_PREP3: begin
                c2_reg <= c2_reg + (c2_reg << 1);
            end
            UOP_LOAD: begin
                h_reg <= c3_reg;
            end
            UOP_MUL_LO: begin
                plo_reg <= PLO_W'(lo_prod) + ROUND_HALF;
            end
            UOP_MUL_HI: begin
                phi_reg  <= hi_prod[PHI_W-1:0];
                base_reg <= coef_sel + ACC_W'(plo_reg[PLO_W-1:FRAC_W]);
            end
            UOP_ADD: begin
                h_reg <= {phi_reg, {FRAC_W{1'b0}}} + base_reg;
            end
            UOP_DIV_INIT: begin
                qv_reg  <= v_init;
                // a negative dividend starts as -1 = -1*6 + 5
                rem_reg <= v_init[ACC_W-1] ? REM_W'(DIVISOR - 1) : '0;
            end
            UOP_DIV: begin
                qv_reg  <= {qv_reg[ACC_W-DIG_W-1:0], qd};
                rem_reg <= rem_full[REM_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Saturate the quotient to the coordinate range
    assign upper    = qv_reg[ACC_W-1:COORD_WIDTH-1];
    assign in_range = (&upper) | (~|upper);
    assign sample   = in_range ? qv_reg[COORD_WIDTH-1:0]
                    : (qv_reg[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

// File: rtl/core/cubic_bspline_curve_sampler.sv
`timescale 1ns / 1ps
// Top level of the uniform cubic B-spline curve sampler.
//
// Control points (signed fixed point) enter one per transaction; the block keeps the last three.
// A point that completes a window of four starts one segment of SAMPLES_PER_SEGMENT+1 curve
// samples at t = j/SAMPLES_PER_SEGMENT, each carrying a saturating running point number, with
// m_run_end set on the last one; last_point clears the window after its own segment. A point
// that only fills the window is taken without starting a segment; one marked last_point clears
// the window at once. The input stays closed while a segment runs. Every sample costs 17 steps
// of the microcode, namely a load, three Horner steps (each a low multiply, a high multiply and
// an add) through a 32x17 low-half and a 32x18 high-half product per coordinate lane, a divide
// set-up, a divide by six of four 16-bit digits, one emit step and one step that advances t.
// An output stall is hidden behind the next sample's computation until that sample reaches its
// emit step, which then waits for the output register to drain. The next control point is taken
// while the last sample still waits in the output register.
module cubic_bspline_curve_sampler #(
    parameter int SAMPLES_PER_SEGMENT = bspl_pkg::SAMPLES_PER_SEGMENT_DEF,
    parameter int COORD_WIDTH         = bspl_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_x_coord,
    input  logic signed [COORD_WIDTH-1:0] s_y_coord,
    input  logic                          s_last_point,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_curve_x,
    output logic signed [COORD_WIDTH-1:0] m_curve_y,
    output logic [bspl_pkg::PNUM_W-1:0]   m_point_number,
    output logic                          m_run_end
);
    import bspl_pkg::*;

    localparam int WIN_DEPTH = 3;
    localparam logic [1:0] WIN_FULL = 2'(WIN_DEPTH);
    localparam int T_ONE     = 1 << FRAC_W;
    localparam int TWO_N     = 2 * SAMPLES_PER_SEGMENT;
    // t advances by 2^17 / 2N per sample, tracked as quotient and remainder
    localparam int T_STEP_Q  = (2 * T_ONE) / TWO_N;
    localparam int T_STEP_R  = (2 * T_ONE) % TWO_N;
    localparam int TREM_W    = $clog2(2 * TWO_N);
    localparam int J_W       = $clog2(SAMPLES_PER_SEGMENT + 1);
    localparam logic [J_W-1:0] J_LAST = J_W'(SAMPLES_PER_SEGMENT);

    dp_ctrl_t    dp_ctrl;
    seq_status_t seq_status;
    logic        seq_in_ready;

    logic [COORD_WIDTH-1:0] win_x_reg [WIN_DEPTH];
    logic [COORD_WIDTH-1:0] win_y_reg [WIN_DEPTH];
    logic [COORD_WIDTH-1:0] p3_x_reg, p3_y_reg;
    logic                   last_reg;
    logic [1:0]             fill_reg, fill_next;

    logic [T_W-1:0]    t_reg;
    logic [TREM_W-1:0] trem_reg, trem_sum;
    logic [J_W-1:0]    j_reg;
    logic [PNUM_W-1:0] count_reg, count_next;

    logic                   m_valid_reg;
    logic [COORD_WIDTH-1:0] m_x_reg, m_y_reg;
    logic [PNUM_W-1:0]      m_pnum_reg;
    logic                   m_end_reg;

    logic in_fire, start, out_busy, more_samples, emit_fire;
    logic signed [COORD_WIDTH-1:0] lane_x, lane_y;

    // Handshake and sequencer status
    assign in_fire      = s_valid && s_ready;
    assign start        = in_fire && (fill_reg == WIN_FULL);
    assign out_busy     = m_valid_reg && !m_ready;
    assign more_samples = (j_reg != J_LAST);
    assign emit_fire    = (dp_ctrl.uop == UOP_EMIT) && !out_busy;
    assign seq_status   = '{start: start, out_busy: out_busy, more_samples: more_samples};
    assign s_ready      = seq_in_ready;

    bspl_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (seq_status),
        .dp_ctrl  (dp_ctrl),
        .in_ready (seq_in_ready)
    );

    bspl_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .aclk    (aclk),
        .dp_ctrl (dp_ctrl),
        .p0      (win_x_reg[0]),
        .p1      (win_x_reg[1]),
        .p2      (win_x_reg[2]),
        .p3      (p3_x_reg),
        .t       (t_reg),
        .sample  (lane_x)
    );

    bspl_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .aclk    (aclk),
        .dp_ctrl (dp_ctrl),
        .p0      (win_y_reg[0]),
        .p1      (win_y_reg[1]),
        .p2      (win_y_reg[2]),
        .p3      (p3_y_reg),
        .t       (t_reg),
        .sample  (lane_y)
    );

    // Window fill level
    always_comb begin
        fill_next = fill_reg;
        if (in_fire && fill_reg != WIN_FULL) begin
            fill_next = s_last_point ? 2'd0 : fill_reg + 2'd1;
        end else if (dp_ctrl.uop == UOP_DONE && last_reg) begin
            fill_next = 2'd0;
        end
    end

    // Window contents: fill in order, slide after a segment
    always_ff @(posedge aclk) begin
        if (in_fire && fill_reg != WIN_FULL) begin
            win_x_reg[fill_reg] <= s_x_coord;
            win_y_reg[fill_reg] <= s_y_coord;
        end else if (dp_ctrl.uop == UOP_DONE) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_x_reg[i] <= win_x_reg[i+1];
                win_y_reg[i] <= win_y_reg[i+1];
            end
            win_x_reg[WIN_DEPTH-1] <= p3_x_reg;
            win_y_reg[WIN_DEPTH-1] <= p3_y_reg;
        end
        if (start) begin
            p3_x_reg <= s_x_coord;
            p3_y_reg <= s_y_coord;
            last_reg <= s_last_point;
        end
    end

    // Sample parameter generator
    assign trem_sum = trem_reg + TREM_W'(T_STEP_R);

    always_ff @(posedge aclk) begin
        if (dp_ctrl.uop == UOP_PREP3) begin
            t_reg    <= '0;
            trem_reg <= TREM_W'(SAMPLES_PER_SEGMENT);
        end else if (dp_ctrl.uop == UOP_NEXT && more_samples) begin
            if (trem_sum >= TREM_W'(TWO_N)) begin
                trem_reg <= trem_sum - TREM_W'(TWO_N);
                t_reg    <= t_reg + T_W'(T_STEP_Q + 1);
            end else begin
                trem_reg <= trem_sum;
                t_reg    <= t_reg + T_W'(T_STEP_Q);
            end
        end
    end

    // Saturating point count
    assign count_next = (count_reg == {PNUM_W{1'b1}}) ? count_reg : count_reg + 1'b1;

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            j_reg     <= '0;
            count_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            if (dp_ctrl.uop == UOP_PREP3) begin
                j_reg <= '0;
            end else if (dp_ctrl.uop == UOP_NEXT && more_samples) begin
                j_reg <= j_reg + 1'b1;
            end
            if (emit_fire) begin
                count_reg <= count_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_x_reg    <= lane_x;
            m_y_reg    <= lane_y;
            m_pnum_reg <= count_next;
            m_end_reg  <= (j_reg == J_LAST);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_curve_x      = m_x_reg;
    assign m_curve_y      = m_y_reg;
    assign m_point_number = m_pnum_reg;
    assign m_run_end      = m_end_reg;

    // A point that starts a segment closes the input until the segment ends
    a_start_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready)
        else $error("input still open after a segment start");

    // The window slides only after the last sample of the segment
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_ctrl.uop == UOP_DONE) |-> (j_reg == J_LAST))
        else $error("segment finished before its last sample");

    // The last sample of a segment is taken at t = 1.0
    a_last_t_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && j_reg == J_LAST) |-> (t_reg == T_W'(T_ONE)))
        else $error("curve parameter not at 1.0 on the last sample");

endmodule
